FILE: rtl/pcwp_pkg.sv
// Shared types, constants and code table functions for the prefix code word packer.
package pcwp_pkg;

   localparam int NSYM = 48;
   localparam int PAYLOAD_BITS = 28;
   localparam logic [NSYM*8-1:0] SYM_STR =
      " rtoeanismcylgfwdvpbhxuq0123456789j-k.z/;:!+@*,?";

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_BAD_CHAR = 2'd2;

   localparam logic KIND_CELL = 1'b0;
   localparam logic KIND_CHAR = 1'b1;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic       hit;
      logic [5:0] idx;
   } sym_lookup_type;

   typedef struct packed {
      logic load;
      logic step;
      logic clear;
   } enc_ctrl_type;

   typedef struct packed {
      logic load;
      logic step;
   } dec_ctrl_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       valid;
      logic       last;
   } dec_result_type;

   function automatic sym_lookup_type sym_lookup(input logic [7:0] ch);
      sym_lookup_type r;
      r.hit = 1'b0;
      r.idx = '0;
      for (int k = 0; k < NSYM; k++) begin
         if (SYM_STR[(NSYM-1-k)*8 +: 8] == ch) begin
            r.hit = 1'b1;
            r.idx = 6'(k);
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] sym_char(input logic [5:0] idx);
      logic [7:0] c;
      c = 8'h00;
      for (int k = 0; k < NSYM; k++) begin
         if (6'(k) == idx) begin
            c = SYM_STR[(NSYM-1-k)*8 +: 8];
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/pcwp_encoder.sv
// Encode accumulator: appends one code per request, then aligns the cell by four or one bit.
module pcwp_encoder import pcwp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  enc_ctrl_type ctrl,
   input  logic [7:0]   in_char,
   output logic         aligned,
   output logic [31:0]  cell_word,
   output logic [1:0]   error
);

   logic [PAYLOAD_BITS-1:0] acc_ff, acc_in;
   logic [4:0]              rem_ff, rem_in;
   logic                    ovf_ff, ovf_in;
   logic                    bad_ff, bad_in;

   sym_lookup_type          look;
   logic [2:0]              len;
   logic [6:0]              code;
   logic [PAYLOAD_BITS-1:0] acc_app;

   always_comb begin
      look = sym_lookup(in_char);
      if (look.idx < 6'd8) begin
         len     = 3'd4;
         code    = {1'b0, look.idx};
         acc_app = {acc_ff[PAYLOAD_BITS-5:0], code[3:0]};
      end else if (look.idx < 6'd16) begin
         len     = 3'd5;
         code    = {1'b0, look.idx} + 7'd8;
         acc_app = {acc_ff[PAYLOAD_BITS-6:0], code[4:0]};
      end else begin
         len     = 3'd7;
         code    = {1'b0, look.idx} + 7'd80;
         acc_app = {acc_ff[PAYLOAD_BITS-8:0], code};
      end
   end

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      ovf_in = ovf_ff;
      bad_in = bad_ff;
      if (ctrl.clear) begin
         acc_in = '0;
         rem_in = 5'(PAYLOAD_BITS);
         ovf_in = 1'b0;
         bad_in = 1'b0;
      end else if (ctrl.load) begin
         if (!look.hit) begin
            bad_in = 1'b1;
         end else if (!ovf_ff) begin
            if ({2'b00, len} > rem_ff) begin
               ovf_in = 1'b1;
            end else begin
               acc_in = acc_app;
               rem_in = rem_ff - {2'b00, len};
            end
         end
      end else if (ctrl.step) begin
         if (rem_ff >= 5'd4) begin
            acc_in = {acc_ff[PAYLOAD_BITS-5:0], 4'b0000};
            rem_in = rem_ff - 5'd4;
         end else if (rem_ff != 5'd0) begin
            acc_in = {acc_ff[PAYLOAD_BITS-2:0], 1'b0};
            rem_in = rem_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         rem_ff <= 5'(PAYLOAD_BITS);
         ovf_ff <= 1'b0;
         bad_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
         ovf_ff <= ovf_in;
         bad_ff <= bad_in;
      end
   end

   assign aligned   = (rem_ff == 5'd0);
   assign cell_word = {acc_ff, 4'b0000};
   assign error     = bad_ff ? ERR_BAD_CHAR : (ovf_ff ? ERR_OVERFLOW : ERR_NONE);

endmodule

FILE: rtl/pcwp_decoder.sv
// Decode shift register: takes one code from the top of the cell per step.
module pcwp_decoder import pcwp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  dec_ctrl_type   ctrl,
   input  logic [31:0]    in_word,
   output dec_result_type result
);

   logic [PAYLOAD_BITS-1:0] shift_ff, shift_in;
   logic [PAYLOAD_BITS-1:0] shift_next;
   logic [3:0]              nib;
   logic [3:0]              grp;
   logic [5:0]              idx;

   always_comb begin
      nib = shift_ff[PAYLOAD_BITS-1 -: 4];
      grp = nib - 4'd10;
      if (!nib[3]) begin
         idx        = {2'b00, nib};
         shift_next = {shift_ff[PAYLOAD_BITS-5:0], 4'b0000};
      end else if (!nib[2]) begin
         idx        = {3'b001, nib[1:0], shift_ff[PAYLOAD_BITS-5]};
         shift_next = {shift_ff[PAYLOAD_BITS-6:0], 5'b00000};
      end else begin
         idx        = {grp[2:0], shift_ff[PAYLOAD_BITS-5 -: 3]};
         shift_next = {shift_ff[PAYLOAD_BITS-8:0], 7'b0000000};
      end
      result.valid = (shift_ff != '0);
      result.ch    = result.valid ? sym_char(idx) : 8'h00;
      result.last  = (shift_next == '0);
   end

   always_comb begin
      shift_in = shift_ff;
      if (ctrl.load) begin
         shift_in = in_word[31:4];
      end else if (ctrl.step) begin
         shift_in = shift_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else begin
         shift_ff <= shift_in;
      end
   end

endmodule

FILE: rtl/prefix_code_word_packer.sv
// Top level of the prefix code word packer: control sequencer and result register.
//
// Request channel (req_*): one request is an encode of one character
// (opcode 0) or a decode of one packed 32-bit cell (opcode 1). A request is
// taken when req_valid is high and req_stall is low.
// Encode: a request without in_last is absorbed and gives no result; encode
// requests can follow each other every cycle. A request with
// in_last appends its character, then the cell is left-aligned four bits or
// one bit per cycle until no payload bits are left unused, and the cell result
// is registered once the output register is free.
// Decode: the cell goes into a shift register that yields one character per
// cycle when not stalled; 1 to 7 results, the last marked with rsp_out_last.
// Response channel (rsp_*): one output register. While rsp_stall is high the
// result holds and no new result is placed; req_stall is high until the
// current request has placed its final result in the output register.
// Reset clears the packing state (empty word, no errors) and rsp_valid;
// the other output register fields are not reset.
module prefix_code_word_packer import pcwp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_in_char,
   input  logic        req_in_last,
   input  logic [31:0] req_in_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_kind,
   output logic [31:0] rsp_out_cell,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_out_char_valid,
   output logic        rsp_out_last,
   output logic [1:0]  rsp_out_error
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ALIGN  = 3'b010,
      ST_DECODE = 3'b100
   } state_type;

   state_type      state_ff, state_in;
   enc_ctrl_type   enc_ctrl;
   dec_ctrl_type   dec_ctrl;
   dec_result_type dec_res;
   logic           enc_aligned;
   logic [31:0]    enc_cell;
   logic [1:0]     enc_error;
   logic           req_accept;
   logic           out_free;
   logic           enc_emit;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [31:0] cell_ff, cell_in;
   logic [7:0]  char_ff, char_in;
   logic        cvalid_ff, cvalid_in;
   logic        last_ff, last_in;
   logic [1:0]  error_ff, error_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign enc_emit   = (state_ff == ST_ALIGN) && enc_aligned && out_free;

   always_comb begin
      enc_ctrl.load  = req_accept && (req_opcode == OP_ENCODE);
      enc_ctrl.step  = (state_ff == ST_ALIGN) && !enc_aligned;
      enc_ctrl.clear = enc_emit;
      dec_ctrl.load  = req_accept && (req_opcode == OP_DECODE);
      dec_ctrl.step  = (state_ff == ST_DECODE) && out_free;
   end

   pcwp_encoder u_encoder (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (enc_ctrl),
      .in_char   (req_in_char),
      .aligned   (enc_aligned),
      .cell_word (enc_cell),
      .error     (enc_error)
   );

   pcwp_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (dec_ctrl),
      .in_word (req_in_word),
      .result  (dec_res)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_opcode == OP_DECODE) begin
                  state_in = ST_DECODE;
               end else if (req_in_last) begin
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_ALIGN: begin
            if (enc_emit) begin
               state_in = ST_IDLE;
            end
         end
         ST_DECODE: begin
            if (dec_ctrl.step && dec_res.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      cell_in      = cell_ff;
      char_in      = char_ff;
      cvalid_in    = cvalid_ff;
      last_in      = last_ff;
      error_in     = error_ff;
      if (enc_emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_CELL;
         cell_in      = enc_cell;
         char_in      = 8'h00;
         cvalid_in    = 1'b0;
         last_in      = 1'b1;
         error_in     = enc_error;
      end else if (dec_ctrl.step) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_CHAR;
         cell_in      = '0;
         char_in      = dec_res.ch;
         cvalid_in    = dec_res.valid;
         last_in      = dec_res.last;
         error_in     = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      cell_ff   <= cell_in;
      char_ff   <= char_in;
      cvalid_ff <= cvalid_in;
      last_ff   <= last_in;
      error_ff  <= error_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_kind       = kind_ff;
   assign rsp_out_cell       = cell_ff;
   assign rsp_out_char       = char_ff;
   assign rsp_out_char_valid = cvalid_ff;
   assign rsp_out_last       = last_ff;
   assign rsp_out_error      = error_ff;

`ifndef SYNTHESIS
   a_last_enc_aligns: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_opcode == OP_ENCODE) && req_in_last) |=> (state_ff == ST_ALIGN))
      else $error("encode last request did not start cell alignment");

   a_cell_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_out_kind == KIND_CELL)) |-> (rsp_out_last && !rsp_out_char_valid))
      else $error("cell result not marked last or carries a character");

   a_cell_tag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_out_kind == KIND_CELL)) |-> (rsp_out_cell[3:0] == 4'h0))
      else $error("cell result has nonzero tag bits");

   a_char_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_out_kind == KIND_CHAR)) |->
         ((rsp_out_cell == 32'h0) && (rsp_out_error == ERR_NONE)))
      else $error("character result carries cell bits or an error");

   a_busy_after_decode: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_opcode == OP_DECODE)) |=> req_stall)
      else $error("decode request did not hold off the request channel");
`endif

endmodule
